FILE: src/ccks_pkg.sv
// Shared types and constants for the ChaCha keystream block.
`default_nettype none

package ccks_pkg;

	localparam int WORD_W     = 32;
	localparam int OUT_W      = 64;
	localparam int STATE_N    = 16;
	localparam int IDX_W      = 3;
	localparam int DR_W       = 4;
	localparam int RND_W      = DR_W + 1;
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_SEL_W  = 3;

	localparam logic [DR_W-1:0]  DR_RESET = DR_W'(10);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(7);

	// Register indexes, byte address 8*i
	localparam logic [REG_SEL_W-1:0] REG_KEY_0      = 3'd0;
	localparam logic [REG_SEL_W-1:0] REG_KEY_1      = 3'd1;
	localparam logic [REG_SEL_W-1:0] REG_KEY_2      = 3'd2;
	localparam logic [REG_SEL_W-1:0] REG_KEY_3      = 3'd3;
	localparam logic [REG_SEL_W-1:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [REG_SEL_W-1:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [REG_SEL_W-1:0] REG_DROUNDS    = 3'd6;

	// "expand 32-byte k"
	localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
	localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
	localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
	localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

	localparam int ROT_0 = 16;
	localparam int ROT_1 = 12;
	localparam int ROT_2 = 8;
	localparam int ROT_3 = 7;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [3:0][OUT_W-1:0] key;
		logic [OUT_W-1:0]      nonce_low;
		logic [WORD_W-1:0]     nonce_high;
		logic [DR_W-1:0]       drounds;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             round;
		logic             diag;
		logic             add;
		logic [IDX_W-1:0] idx;
	} cmd_t;

endpackage

`default_nettype wire

FILE: src/ccks_req_if.sv
// Request channel: one block request per word.
`default_nettype none

interface ccks_req_if;
	logic                        valid;
	logic                        ready;
	logic                        load_counter;
	logic [ccks_pkg::WORD_W-1:0] counter_value;

	modport source(output valid, output load_counter, output counter_value, input ready);
	modport sink(input valid, input load_counter, input counter_value, output ready);
endinterface

`default_nettype wire

FILE: src/ccks_ks_if.sv
// Keystream channel: eight 64-bit words per block.
`default_nettype none

interface ccks_ks_if;
	logic                       valid;
	logic                       ready;
	logic [ccks_pkg::OUT_W-1:0] keystream_word;
	logic [ccks_pkg::IDX_W-1:0] word_index;
	logic                       last_word;

	modport source(output valid, output keystream_word, output word_index,
		output last_word, input ready);
	modport sink(input valid, input keystream_word, input word_index,
		input last_word, output ready);
endinterface

`default_nettype wire

FILE: src/ccks_cfg_regs.sv
// APB configuration registers: key, nonce and double round count.
`default_nettype none

module ccks_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ccks_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ccks_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ccks_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output ccks_pkg::cfg_t                       cfg
);

	ccks_pkg::cfg_t                   cfg_q;
	logic [ccks_pkg::REG_SEL_W-1:0] sel;
	logic                             wr_en;

	assign sel    = paddr[ccks_pkg::APB_ADDR_W-1:3];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{key: '0, nonce_low: '0, nonce_high: '0,
				drounds: ccks_pkg::DR_RESET};
		end else if (wr_en) begin
			unique case (sel)
				ccks_pkg::REG_KEY_0:      cfg_q.key[0]     <= pwdata;
				ccks_pkg::REG_KEY_1:      cfg_q.key[1]     <= pwdata;
				ccks_pkg::REG_KEY_2:      cfg_q.key[2]     <= pwdata;
				ccks_pkg::REG_KEY_3:      cfg_q.key[3]     <= pwdata;
				ccks_pkg::REG_NONCE_LOW:  cfg_q.nonce_low  <= pwdata;
				ccks_pkg::REG_NONCE_HIGH: cfg_q.nonce_high <= pwdata[ccks_pkg::WORD_W-1:0];
				ccks_pkg::REG_DROUNDS:    cfg_q.drounds    <= pwdata[ccks_pkg::DR_W-1:0];
				default: begin
					// drop writes past the register list
				end
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			ccks_pkg::REG_KEY_0:      prdata = cfg_q.key[0];
			ccks_pkg::REG_KEY_1:      prdata = cfg_q.key[1];
			ccks_pkg::REG_KEY_2:      prdata = cfg_q.key[2];
			ccks_pkg::REG_KEY_3:      prdata = cfg_q.key[3];
			ccks_pkg::REG_NONCE_LOW:  prdata = cfg_q.nonce_low;
			ccks_pkg::REG_NONCE_HIGH: prdata = ccks_pkg::APB_DATA_W'(cfg_q.nonce_high);
			ccks_pkg::REG_DROUNDS:    prdata = ccks_pkg::APB_DATA_W'(cfg_q.drounds);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/ccks_ctrl.sv
// Block sequencer: request accept, round count, final add, word output.
`default_nettype none

module ccks_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	input  wire logic [ccks_pkg::DR_W-1:0]    drounds,
	output ccks_pkg::cmd_t                    cmd,
	output logic      [ccks_pkg::IDX_W-1:0]   word_index,
	output logic                              last_word
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]                     state_q;
	logic [ccks_pkg::RND_W-1:0]     rnd_q;
	logic [ccks_pkg::IDX_W-1:0]     idx_q;
	logic                           in_fire;
	logic                           out_fire;
	logic                           rnd_last;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	// last half round is 2*drounds - 1
	assign rnd_last  = (rnd_q == ({drounds, 1'b0} - ccks_pkg::RND_W'(1)));

	assign word_index = idx_q;
	assign last_word  = (idx_q == ccks_pkg::IDX_LAST);

	always_comb begin
		cmd       = '0;
		cmd.load  = in_fire;
		cmd.round = (state_q == ST_ROUND);
		cmd.diag  = rnd_q[0];
		cmd.add   = (state_q == ST_ADD);
		cmd.idx   = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					rnd_q <= '0;
					idx_q <= '0;
					if (in_fire) begin
						state_q <= (drounds == '0) ? ST_ADD : ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + ccks_pkg::RND_W'(1);
					if (rnd_last) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_fire) begin
						idx_q <= idx_q + ccks_pkg::IDX_W'(1);
						if (last_word) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != ST_IDLE))
		else $error("accepted request did not start a block");

	a_last_word_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_word) |=> (state_q == ST_IDLE))
		else $error("block did not end after its last word");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q < {drounds, 1'b0}))
		else $error("round counter ran past the configured count");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request taken while keystream words pending");
`endif

endmodule

`default_nettype wire

FILE: src/ccks_datapath.sv
// Round datapath: 16-word working state, four quarter rounds per cycle, feed-forward add.
`default_nettype none

module ccks_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ccks_pkg::cfg_t                cfg,
	input  wire ccks_pkg::cmd_t                cmd,
	input  wire logic                          load_counter,
	input  wire logic [ccks_pkg::WORD_W-1:0]   counter_value,
	output logic      [ccks_pkg::OUT_W-1:0]    keystream_word
);

	typedef struct packed {
		ccks_pkg::word_t a;
		ccks_pkg::word_t b;
		ccks_pkg::word_t c;
		ccks_pkg::word_t d;
	} qr_t;

	function automatic ccks_pkg::word_t rotl(input ccks_pkg::word_t x, input int n);
		rotl = (x << n) | (x >> (ccks_pkg::WORD_W - n));
	endfunction

	function automatic qr_t quarter(input qr_t q);
		qr_t r;
		r = q;
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, ccks_pkg::ROT_0);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, ccks_pkg::ROT_1);
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, ccks_pkg::ROT_2);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, ccks_pkg::ROT_3);
		return r;
	endfunction

	ccks_pkg::word_t                  ws_q [ccks_pkg::STATE_N];
	ccks_pkg::word_t                  init_w [ccks_pkg::STATE_N];
	ccks_pkg::word_t                  rnd_w [ccks_pkg::STATE_N];
	logic [ccks_pkg::WORD_W-1:0]      ctr_q;
	logic [ccks_pkg::WORD_W-1:0]      next_ctr_q;
	logic [ccks_pkg::WORD_W-1:0]      ctr_sel;

	assign ctr_sel = load_counter ? counter_value : next_ctr_q;

	// Input state; word 12 is the latched counter, or at load the selected one (counter_value or the next counter).
	always_comb begin
		init_w[0]  = ccks_pkg::SIGMA_0;
		init_w[1]  = ccks_pkg::SIGMA_1;
		init_w[2]  = ccks_pkg::SIGMA_2;
		init_w[3]  = ccks_pkg::SIGMA_3;
		for (int k = 0; k < 4; k++) begin
			init_w[4 + 2*k] = cfg.key[k][ccks_pkg::WORD_W-1:0];
			init_w[5 + 2*k] = cfg.key[k][ccks_pkg::OUT_W-1:ccks_pkg::WORD_W];
		end
		init_w[12] = cmd.load ? ctr_sel : ctr_q;
		init_w[13] = cfg.nonce_low[ccks_pkg::WORD_W-1:0];
		init_w[14] = cfg.nonce_low[ccks_pkg::OUT_W-1:ccks_pkg::WORD_W];
		init_w[15] = cfg.nonce_high;
	end

	// Column round uses lanes (j, 4+j, 8+j, 12+j); diagonal round rotates rows b, c, d by 1, 2, 3.
	always_comb begin
		qr_t qin;
		qr_t qout;
		int  ib;
		int  ic;
		int  id;
		for (int n = 0; n < ccks_pkg::STATE_N; n++) begin
			rnd_w[n] = ws_q[n];
		end
		for (int j = 0; j < 4; j++) begin
			ib = cmd.diag ? 4  + ((j + 1) & 3) : 4  + j;
			ic = cmd.diag ? 8  + ((j + 2) & 3) : 8  + j;
			id = cmd.diag ? 12 + ((j + 3) & 3) : 12 + j;
			qin.a = ws_q[j];
			qin.b = ws_q[ib];
			qin.c = ws_q[ic];
			qin.d = ws_q[id];
			qout = quarter(qin);
			rnd_w[j]  = qout.a;
			rnd_w[ib] = qout.b;
			rnd_w[ic] = qout.c;
			rnd_w[id] = qout.d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int n = 0; n < ccks_pkg::STATE_N; n++) begin
				ws_q[n] <= init_w[n];
			end
			ctr_q <= ctr_sel;
		end else if (cmd.round) begin
			for (int n = 0; n < ccks_pkg::STATE_N; n++) begin
				ws_q[n] <= rnd_w[n];
			end
		end else if (cmd.add) begin
			for (int n = 0; n < ccks_pkg::STATE_N; n++) begin
				ws_q[n] <= ws_q[n] + init_w[n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ctr_q <= '0;
		end else if (cmd.load) begin
			next_ctr_q <= ctr_sel + ccks_pkg::WORD_W'(1);
		end
	end

	assign keystream_word = {ws_q[{cmd.idx, 1'b1}], ws_q[{cmd.idx, 1'b0}]};

endmodule

`default_nettype wire

FILE: src/chacha_keystream_block.sv
// Top level of the ChaCha keystream block generator.
`default_nettype none

// ChaCha keystream block generator, IETF layout (32-bit block counter, 96-bit
// nonce). Program key, nonce and double round count over the APB port while
// the block is idle; register i sits at byte address 8*i, data is 64 bits and
// pready is always high. Each request word on req starts one 64-byte block:
// with load_counter set the block counter is counter_value, otherwise it is
// the counter after the previous block (zero after reset), and the stored
// counter advances by one, wrapping at 2^32 without touching the nonce. The
// block then leaves on ks as eight 64-bit little-endian words, word_index 0
// to 7, last_word high on the eighth; each carries state words 2i (low half)
// and 2i+1 (high half). A block runs in order: take the request and load
// the state, one half double round per cycle (four quarter rounds side by
// side), the feed-forward add, then the eight output words. A new request
// is taken in the cycle after the last word of the previous block has gone.
// A double round count of zero skips the rounds and returns twice the input
// state.
module chacha_keystream_block (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ccks_req_if.sink                             req,
	ccks_ks_if.source                            ks,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [ccks_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [ccks_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [ccks_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready
);

	ccks_pkg::cfg_t cfg;
	ccks_pkg::cmd_t cmd;

	// Hold key, nonce and round count for the datapath and sequencer.
	ccks_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequence load, rounds, add and the eight output words.
	ccks_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.out_valid  (ks.valid),
		.out_ready  (ks.ready),
		.drounds    (cfg.drounds),
		.cmd        (cmd),
		.word_index (ks.word_index),
		.last_word  (ks.last_word)
	);

	// Keep the working state and counter; select the outgoing word by index.
	ccks_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.load_counter   (req.load_counter),
		.counter_value  (req.counter_value),
		.keystream_word (ks.keystream_word)
	);

endmodule

`default_nettype wire
